### src/cdq_pkg.sv
// package: operation codes, transfer structs and cell command struct for the deque
package cdq_pkg;

  // operation codes carried by an input transfer
  typedef enum logic [2:0] {
    OP_NONE       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4
  } op_t;

  // width of the element fields on the ports
  localparam int unsigned PORT_ELEM_W = 16;
  localparam int unsigned PORT_FILL_W = 6;

  // input transfer
  typedef struct packed {
    logic [2:0]             operation;
    logic [PORT_ELEM_W-1:0] push_value;
  } in_item_t;

  // result transfer
  typedef struct packed {
    logic [PORT_ELEM_W-1:0] popped_value;
    logic                   accepted;
    logic [PORT_FILL_W-1:0] fill_count;
    logic                   is_empty;
    logic                   is_full;
    logic [PORT_ELEM_W-1:0] front_value;
    logic [PORT_ELEM_W-1:0] back_value;
  } out_item_t;

  // shift and write commands broadcast to every cell, already qualified
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } cell_cmd_t;

endpackage

### src/circular_deque_ring_buffer.sv
// top level: deque built as a row of cells with the front at cell 0
// result: the result of an operation appears in the cycle after its start transfer
// throughput: one operation per cycle, busy never rises; every cell shifts in the same cycle
// reset: synchronous active-low rst_n empties the deque and drops the result strobe
// the result strobe lasts one cycle and the receiver cannot stall it
module circular_deque_ring_buffer #(
  parameter int unsigned CAPACITY      = 32,
  parameter int unsigned ELEMENT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cdq_pkg::in_item_t  in_data,
  output logic               out_valid,
  output cdq_pkg::out_item_t out_data
);
  import cdq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic                     accept;
  logic                     full, empty;
  logic                     op_ok;
  cell_cmd_t                cmd;
  logic [ELEMENT_WIDTH-1:0] push_word;
  logic [ELEMENT_WIDTH-1:0] front_word, back_word;
  logic [ELEMENT_WIDTH-1:0] popped_word;

  logic [ELEMENT_WIDTH-1:0] cell_data [CAPACITY];
  logic [ELEMENT_WIDTH-1:0] cell_tail [CAPACITY];
  logic [CAPACITY-1:0]      cell_occ;

  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     out_valid_r;
  logic                     accepted_r;
  logic [ELEMENT_WIDTH-1:0] popped_r;

  assign busy      = 1'b0;
  assign accept    = start & ~busy;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);
  assign push_word = ELEMENT_WIDTH'(in_data.push_value);

  // decode the operation and refuse push on full or pop on empty
  always_comb begin
    cmd         = '0;
    op_ok       = 1'b0;
    popped_word = '0;
    count_nxt   = count_r;
    case (in_data.operation)
      OP_NONE: begin
        op_ok = 1'b1;
      end
      OP_PUSH_FRONT: begin
        op_ok          = ~full;
        cmd.push_front = accept & ~full;
      end
      OP_PUSH_BACK: begin
        op_ok         = ~full;
        cmd.push_back = accept & ~full;
      end
      OP_POP_FRONT: begin
        op_ok         = ~empty;
        cmd.pop_front = accept & ~empty;
        popped_word   = empty ? '0 : front_word;
      end
      OP_POP_BACK: begin
        op_ok        = ~empty;
        cmd.pop_back = accept & ~empty;
        popped_word  = empty ? '0 : back_word;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
    if (cmd.push_front || cmd.push_back) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop_front || cmd.pop_back) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // row of cells, cell 0 takes the pushed word on a front push, last cell sees an empty right side
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEMENT_WIDTH-1:0] prev_data, next_data;
    logic                     prev_occ, next_occ;

    if (i == 0) begin : g_head
      assign prev_data = push_word;
      assign prev_occ  = 1'b1;
    end else begin : g_body
      assign prev_data = cell_data[i-1];
      assign prev_occ  = cell_occ[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_data = '0;
      assign next_occ  = 1'b0;
    end else begin : g_mid
      assign next_data = cell_data[i+1];
      assign next_occ  = cell_occ[i+1];
    end

    cdq_cell #(
      .ELEMENT_WIDTH(ELEMENT_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .push_word(push_word),
      .prev_data(prev_data),
      .prev_occ (prev_occ),
      .next_data(next_data),
      .next_occ (next_occ),
      .data     (cell_data[i]),
      .occ      (cell_occ[i]),
      .tail_data(cell_tail[i])
    );
  end

  // front is cell 0, back is the single cell flagged as tail
  assign front_word = cell_occ[0] ? cell_data[0] : '0;

  always_comb begin
    back_word = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      back_word = back_word | cell_tail[i];
    end
  end

  // count and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // per-transfer result fields
  always_ff @(posedge clk) begin
    if (accept) begin
      accepted_r <= op_ok;
      popped_r   <= popped_word;
    end
  end

  // result fields, peeks taken from the cells after the update
  assign out_valid             = out_valid_r;
  assign out_data.popped_value = PORT_ELEM_W'(popped_r);
  assign out_data.accepted     = accepted_r;
  assign out_data.fill_count   = PORT_FILL_W'(count_r);
  assign out_data.is_empty     = empty;
  assign out_data.is_full      = full;
  assign out_data.front_value  = PORT_ELEM_W'(front_word);
  assign out_data.back_value   = PORT_ELEM_W'(back_word);

endmodule

### src/cdq_cell.sv
// one deque position: holds an element and its occupied flag, talks to both neighbors
module cdq_cell #(
  parameter int unsigned ELEMENT_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cdq_pkg::cell_cmd_t       cmd,
  input  logic [ELEMENT_WIDTH-1:0] push_word,
  input  logic [ELEMENT_WIDTH-1:0] prev_data,
  input  logic                     prev_occ,
  input  logic [ELEMENT_WIDTH-1:0] next_data,
  input  logic                     next_occ,
  output logic [ELEMENT_WIDTH-1:0] data,
  output logic                     occ,
  output logic [ELEMENT_WIDTH-1:0] tail_data
);
  import cdq_pkg::*;

  logic [ELEMENT_WIDTH-1:0] data_r, data_nxt;
  logic                     occ_r, occ_nxt;
  logic                     is_tail;

  assign is_tail = occ_r & ~next_occ;

  // next contents: shift toward the back, shift toward the front, or local write/clear
  always_comb begin
    data_nxt = data_r;
    occ_nxt  = occ_r;
    if (cmd.push_front) begin
      data_nxt = prev_data;
      occ_nxt  = prev_occ;
    end else if (cmd.pop_front) begin
      data_nxt = next_data;
      occ_nxt  = next_occ;
    end else if (cmd.push_back) begin
      // first free position after the occupied run takes the word
      if (!occ_r && prev_occ) begin
        data_nxt = push_word;
        occ_nxt  = 1'b1;
      end
    end else if (cmd.pop_back) begin
      if (is_tail) begin
        occ_nxt = 1'b0;
      end
    end
  end

  // occupied flag is control state, element word needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data      = data_r;
  assign occ       = occ_r;
  assign tail_data = is_tail ? data_r : '0;

endmodule
